// File: design/ilnf_pkg.sv
`default_nettype none
package ilnf_pkg;

    localparam int HEAP_BYTES_DEF  = 65536;
    localparam int CHUNK_BYTES_DEF = 4096;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic        func;
        logic [15:0] req_size;
        logic [15:0] block_addr;
    } req_t;

    typedef struct packed {
        logic [15:0] result_addr;
        logic        ok;
    } rsp_t;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

endpackage
`default_nettype wire

// File: design/ilnf_ram.sv
`default_nettype none
module ilnf_ram #(
    parameter int IDX_W = 14
) (
    input  wire logic               aclk,
    input  wire logic               we,
    input  wire logic [IDX_W-1:0]   waddr,
    input  wire ilnf_pkg::word_t    wdata,
    input  wire logic [IDX_W-1:0]   raddr,
    output ilnf_pkg::word_t         rdata
);

    localparam int DEPTH = 1 << IDX_W;

    ilnf_pkg::word_t mem [DEPTH];
    ilnf_pkg::word_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: design/implicit_list_next_fit_allocator.sv
`default_nettype none
// Operation: a free checks the block header and coalesces; an allocate walks block headers
// with a next-fit search, then ends the walk, grows the heap, coalesces and splits.
// Throughput: one item at a time; the heap word store (one write port, one read port)
// sets the pace, one read or one write per cycle. HEAP_BYTES must be a power of two.
// Reset: after aresetn the store is swept one word per cycle, all HEAP_BYTES/4 words,
// to build prologue, first free block (if it fits) and epilogue; s_ready stays low meanwhile.
module implicit_list_next_fit_allocator #(
    parameter int HEAP_BYTES  = ilnf_pkg::HEAP_BYTES_DEF,
    parameter int CHUNK_BYTES = ilnf_pkg::CHUNK_BYTES_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire ilnf_pkg::req_t s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output ilnf_pkg::rsp_t      m_data
);

    localparam int AW      = $clog2(HEAP_BYTES);
    localparam int IW      = AW - 2;
    localparam int WALK    = HEAP_BYTES / 8 + 2;
    localparam int WALK_W  = $clog2(WALK + 1);
    localparam int CR      = ((CHUNK_BYTES / 4 + 1) / 2) * 8;
    localparam bit FITS    = (16 + CR) <= HEAP_BYTES;
    localparam int INIT_BRK = FITS ? 16 + CR : 16;
    localparam int IDX_FTR = (16 + CR - 8) / 4;
    localparam int IDX_EPI = (16 + CR - 4) / 4;

    typedef enum logic [5:0] {
        ST_CLR, ST_IDLE,
        ST_S1_RD, ST_S1_CHK, ST_S2_RD, ST_S2_CHK,
        ST_GROW, ST_G_HDR, ST_G_FTR, ST_G_EPI,
        ST_F_RD, ST_F_CHK, ST_F_FTR,
        ST_M_A, ST_M_B, ST_M_C, ST_M_D, ST_M_E, ST_M_F,
        ST_M_PA1, ST_M_PA2, ST_M_NA1, ST_M_NA2, ST_M_NA3,
        ST_M_B1, ST_M_B2, ST_M_B3, ST_M_B4, ST_M_B5, ST_M_B6,
        ST_RA0, ST_RA1, ST_M_RET,
        ST_P0, ST_P1, ST_P_S1, ST_P_S2, ST_P_S3, ST_P_S4, ST_P_N1, ST_P_N2,
        ST_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [IW-1:0]   clr_reg, clr_next;
    ilnf_pkg::word_t rover_reg, rover_next;
    ilnf_pkg::word_t brk_reg, brk_next;
    ilnf_pkg::word_t old_reg, old_next;
    logic [WALK_W-1:0] cnt_reg, cnt_next;
    ilnf_pkg::word_t bp_reg, bp_next;
    logic [16:0]     need_reg, need_next;
    ilnf_pkg::word_t psz_reg, psz_next;
    ilnf_pkg::word_t hs_reg, hs_next;
    ilnf_pkg::word_t s_reg, s_next;
    ilnf_pkg::word_t sz_reg, sz_next;
    logic            pa_reg, pa_next;
    logic            mode_reg, mode_next;
    logic [15:0]     addr_reg, addr_next;
    logic [15:0]     res_reg, res_next;
    logic            ok_reg, ok_next;
    logic            m_valid_reg, m_valid_next;
    ilnf_pkg::rsp_t  m_data_reg, m_data_next;

    logic            mem_we;
    logic [IW-1:0]   mem_waddr, mem_raddr;
    ilnf_pkg::word_t mem_wdata, mem_rdata, rsz;

    ilnf_ram #(.IDX_W(IW)) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    function automatic logic [IW-1:0] widx(input ilnf_pkg::word_t a);
        return a[AW-1:2];
    endfunction

    function automatic ilnf_pkg::word_t init_word(input logic [IW-1:0] idx);
        ilnf_pkg::word_t v;
        v = '0;
        if (idx == IW'(1) || idx == IW'(2)) begin
            v = 32'd9;
        end else if (FITS) begin
            if (idx == IW'(3) || idx == IW'(IDX_FTR)) begin
                v = 32'(CR);
            end else if (idx == IW'(IDX_EPI)) begin
                v = 32'd1;
            end
        end else if (idx == IW'(3)) begin
            v = 32'd1;
        end
        return v;
    endfunction

    assign rsz = {mem_rdata[31:3], 3'b000};

    always_comb begin
        ilnf_pkg::word_t need32, gsz, addr32, nx;
        logic [16:0] need_c;
        state_next   = state_reg;
        clr_next     = clr_reg;
        rover_next   = rover_reg;
        brk_next     = brk_reg;
        old_next     = old_reg;
        cnt_next     = cnt_reg;
        bp_next      = bp_reg;
        need_next    = need_reg;
        psz_next     = psz_reg;
        hs_next      = hs_reg;
        s_next       = s_reg;
        sz_next      = sz_reg;
        pa_next      = pa_reg;
        mode_next    = mode_reg;
        addr_next    = addr_reg;
        res_next     = res_reg;
        ok_next      = ok_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_raddr    = '0;
        need32       = {15'b0, need_reg};
        addr32       = {16'b0, addr_reg};
        gsz          = (need32 > 32'(CHUNK_BYTES)) ? need32 : 32'(CR);
        nx           = bp_reg + rsz;
        need_c       = (s_data.req_size <= 16'd8) ? 17'd16
                     : (({1'b0, s_data.req_size} + 17'd15) & 17'h1FFF8);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = init_word(clr_reg);
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    need_next = need_c;
                    addr_next = s_data.block_addr;
                    res_next  = '0;
                    ok_next   = 1'b0;
                    mode_next = s_data.func;
                    old_next  = rover_reg;
                    cnt_next  = '0;
                    if (s_data.func == ilnf_pkg::FUNC_FREE) begin
                        if (s_data.block_addr == '0) begin
                            ok_next    = 1'b1;
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_F_RD;
                        end
                    end else if (s_data.req_size == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_S1_RD;
                    end
                end
            end
            ST_S1_RD: begin
                if (cnt_reg >= WALK_W'(WALK)) begin
                    rover_next = 32'd8;
                    cnt_next   = '0;
                    state_next = ST_S2_RD;
                end else begin
                    mem_raddr  = widx(rover_reg - 32'd4);
                    state_next = ST_S1_CHK;
                end
            end
            ST_S1_CHK: begin
                if (rsz == '0) begin
                    rover_next = 32'd8;
                    cnt_next   = '0;
                    state_next = ST_S2_RD;
                end else if (!mem_rdata[0] && need32 <= rsz) begin
                    bp_next    = rover_reg;
                    state_next = ST_P0;
                end else begin
                    rover_next = rover_reg + rsz;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_S1_RD;
                end
            end
            ST_S2_RD: begin
                if (cnt_reg >= WALK_W'(WALK) || !(rover_reg < old_reg)) begin
                    state_next = ST_GROW;
                end else begin
                    mem_raddr  = widx(rover_reg - 32'd4);
                    state_next = ST_S2_CHK;
                end
            end
            ST_S2_CHK: begin
                if (!mem_rdata[0] && need32 <= rsz) begin
                    bp_next    = rover_reg;
                    state_next = ST_P0;
                end else begin
                    rover_next = rover_reg + rsz;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_S2_RD;
                end
            end
            ST_GROW: begin
                if ({1'b0, brk_reg} + {1'b0, gsz} > 33'(HEAP_BYTES)) begin
                    state_next = ST_DONE;
                end else begin
                    bp_next    = brk_reg;
                    brk_next   = brk_reg + gsz;
                    sz_next    = gsz;
                    state_next = ST_G_HDR;
                end
            end
            ST_G_HDR: begin
                mem_we     = 1'b1;
                mem_waddr  = widx(bp_reg - 32'd4);
                mem_wdata  = sz_reg;
                state_next = ST_G_FTR;
            end
            ST_G_FTR: begin
                mem_we     = 1'b1;
                mem_waddr  = widx(bp_reg + sz_reg - 32'd8);
                mem_wdata  = sz_reg;
                state_next = ST_G_EPI;
            end
            ST_G_EPI: begin
                mem_we     = 1'b1;
                mem_waddr  = widx(bp_reg + sz_reg - 32'd4);
                mem_wdata  = 32'd1;
                state_next = ST_M_A;
            end
            ST_F_RD: begin
                mem_raddr  = widx(addr32 - 32'd4);
                state_next = ST_F_CHK;
            end
            ST_F_CHK: begin
                if (addr_reg[2:0] == 3'b000 && addr32 >= 32'd16 && addr32 < brk_reg &&
                    mem_rdata[0] && rsz >= 32'd16 &&
                    {1'b0, addr32} + {1'b0, rsz} <= {1'b0, brk_reg}) begin
                    mem_we     = 1'b1;
                    mem_waddr  = widx(addr32 - 32'd4);
                    mem_wdata  = rsz;
                    sz_next    = rsz;
                    bp_next    = addr32;
                    ok_next    = 1'b1;
                    state_next = ST_F_FTR;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_F_FTR: begin
                mem_we     = 1'b1;
                mem_waddr  = widx(bp_reg + sz_reg - 32'd8);
                mem_wdata  = sz_reg;
                state_next = ST_M_A;
            end
            // coalesce: walk previous footer/header, own header, next header
            ST_M_A: begin
                mem_raddr  = widx(bp_reg - 32'd8);
                state_next = ST_M_B;
            end
            ST_M_B: begin
                psz_next   = rsz;
                mem_raddr  = widx(bp_reg - rsz - 32'd4);
                state_next = ST_M_C;
            end
            ST_M_C: begin
                hs_next    = rsz;
                mem_raddr  = widx(bp_reg - psz_reg + rsz - 32'd8);
                state_next = ST_M_D;
            end
            ST_M_D: begin
                pa_next    = mem_rdata[0];
                mem_raddr  = widx(bp_reg - 32'd4);
                state_next = ST_M_E;
            end
            ST_M_E: begin
                s_next     = rsz;
                mem_raddr  = widx(bp_reg + rsz - 32'd4);
                state_next = ST_M_F;
            end
            ST_M_F: begin
                if (pa_reg && mem_rdata[0]) begin
                    state_next = ST_M_RET;
                end else if (pa_reg) begin
                    sz_next    = s_reg + rsz;
                    state_next = ST_M_PA1;
                end else if (mem_rdata[0]) begin
                    sz_next    = s_reg + hs_reg;
                    state_next = ST_M_NA1;
                end else begin
                    mem_raddr  = widx(bp_reg + s_reg + rsz - 32'd8);
                    state_next = ST_M_B1;
                end
            end
            ST_M_PA1: begin
                mem_we     = 1'b1;
                mem_waddr  = widx(bp_reg - 32'd4);
                mem_wdata  = sz_reg;
                state_next = ST_M_PA2;
            end
            ST_M_PA2: begin
                mem_we     = 1'b1;
                mem_waddr  = widx(bp_reg + {sz_reg[31:3], 3'b000} - 32'd8);
                mem_wdata  = sz_reg;
                state_next = ST_RA0;
            end
            ST_M_NA1: begin
                mem_we     = 1'b1;
                mem_waddr  = widx(bp_reg + s_reg - 32'd8);
                mem_wdata  = sz_reg;
                state_next = ST_M_NA2;
            end
            ST_M_NA2: begin
                mem_raddr  = widx(bp_reg - 32'd8);
                state_next = ST_M_NA3;
            end
            ST_M_NA3: begin
                mem_we     = 1'b1;
                mem_waddr  = widx(bp_reg - rsz - 32'd4);
                mem_wdata  = sz_reg;
                bp_next    = bp_reg - rsz;
                state_next = ST_RA0;
            end
            ST_M_B1: begin
                sz_next    = s_reg + hs_reg + rsz;
                mem_we     = 1'b1;
                mem_waddr  = widx(bp_reg - psz_reg - 32'd4);
                mem_wdata  = s_reg + hs_reg + rsz;
                state_next = ST_M_B2;
            end
            ST_M_B2: begin
                mem_raddr  = widx(bp_reg - 32'd4);
                state_next = ST_M_B3;
            end
            ST_M_B3: begin
                s_next     = rsz;
                mem_raddr  = widx(bp_reg + rsz - 32'd4);
                state_next = ST_M_B4;
            end
            ST_M_B4: begin
                mem_we     = 1'b1;
                mem_waddr  = widx(bp_reg + s_reg + rsz - 32'd8);
                mem_wdata  = sz_reg;
                state_next = ST_M_B5;
            end
            ST_M_B5: begin
                mem_raddr  = widx(bp_reg - 32'd8);
                state_next = ST_M_B6;
            end
            ST_M_B6: begin
                bp_next    = bp_reg - rsz;
                state_next = ST_RA0;
            end
            // pull the rover back if it lands inside the merged block
            ST_RA0: begin
                mem_raddr  = widx(bp_reg - 32'd4);
                state_next = ST_RA1;
            end
            ST_RA1: begin
                if (rover_reg > bp_reg && rover_reg < nx) begin
                    rover_next = bp_reg;
                end
                state_next = ST_M_RET;
            end
            ST_M_RET: begin
                state_next = (mode_reg == ilnf_pkg::FUNC_FREE) ? ST_DONE : ST_P0;
            end
            ST_P0: begin
                mem_raddr  = widx(bp_reg - 32'd4);
                state_next = ST_P1;
            end
            ST_P1: begin
                sz_next = rsz;
                if (rsz - need32 >= 32'd16 && rsz >= need32) begin
                    state_next = ST_P_S1;
                end else begin
                    state_next = ST_P_N1;
                end
            end
            ST_P_S1: begin
                mem_we     = 1'b1;
                mem_waddr  = widx(bp_reg - 32'd4);
                mem_wdata  = need32 | 32'd1;
                state_next = ST_P_S2;
            end
            ST_P_S2: begin
                mem_we     = 1'b1;
                mem_waddr  = widx(bp_reg + need32 - 32'd8);
                mem_wdata  = need32 | 32'd1;
                state_next = ST_P_S3;
            end
            ST_P_S3: begin
                mem_we     = 1'b1;
                mem_waddr  = widx(bp_reg + need32 - 32'd4);
                mem_wdata  = sz_reg - need32;
                state_next = ST_P_S4;
            end
            ST_P_S4: begin
                mem_we     = 1'b1;
                mem_waddr  = widx(bp_reg + sz_reg - 32'd8);
                mem_wdata  = sz_reg - need32;
                res_next   = bp_reg[15:0];
                ok_next    = 1'b1;
                state_next = ST_DONE;
            end
            ST_P_N1: begin
                mem_we     = 1'b1;
                mem_waddr  = widx(bp_reg - 32'd4);
                mem_wdata  = sz_reg | 32'd1;
                state_next = ST_P_N2;
            end
            ST_P_N2: begin
                mem_we     = 1'b1;
                mem_waddr  = widx(bp_reg + sz_reg - 32'd8);
                mem_wdata  = sz_reg | 32'd1;
                res_next   = bp_reg[15:0];
                ok_next    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.result_addr = res_reg;
                    m_data_next.ok          = ok_reg;
                    state_next              = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            clr_reg     <= '0;
            rover_reg   <= 32'd8;
            brk_reg     <= 32'(INIT_BRK);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            rover_reg   <= rover_next;
            brk_reg     <= brk_next;
            m_valid_reg <= m_valid_next;
        end
        old_reg    <= old_next;
        cnt_reg    <= cnt_next;
        bp_reg     <= bp_next;
        need_reg   <= need_next;
        psz_reg    <= psz_next;
        hs_reg     <= hs_next;
        s_reg      <= s_next;
        sz_reg     <= sz_next;
        pa_reg     <= pa_next;
        mode_reg   <= mode_next;
        addr_reg   <= addr_next;
        res_reg    <= res_next;
        ok_reg     <= ok_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// File: tb/implicit_list_next_fit_allocator_checker.sv
`timescale 1ns / 1ps
module implicit_list_next_fit_allocator_checker #(
    parameter int HEAP_BYTES  = ilnf_pkg::HEAP_BYTES_DEF,
    parameter int CHUNK_BYTES = ilnf_pkg::CHUNK_BYTES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  ilnf_pkg::req_t s_data,
    input  logic           m_valid,
    input  logic           m_ready,
    input  ilnf_pkg::rsp_t m_data,
    output int             fail_count
);

    localparam int unsigned WORDS     = HEAP_BYTES / 4;
    localparam int unsigned WALK_MAX  = HEAP_BYTES / 8 + 2;
    localparam int unsigned FIRST_BP  = 8;

    ilnf_pkg::word_t heap_mem [WORDS];
    int unsigned     rover;
    int unsigned     brk;
    ilnf_pkg::rsp_t  expected_rsp [$];

    function automatic ilnf_pkg::word_t mem_rd(int unsigned a);
        return heap_mem[(a >> 2) % WORDS];
    endfunction

    function automatic void mem_wr(int unsigned a, ilnf_pkg::word_t v);
        heap_mem[(a >> 2) % WORDS] = v;
    endfunction

    function automatic int unsigned tag_size(int unsigned a);
        return mem_rd(a) & ~32'd7;
    endfunction

    function automatic bit tag_used(int unsigned a);
        ilnf_pkg::word_t w;
        w = mem_rd(a);
        return w[0];
    endfunction

    function automatic int unsigned foot_of(int unsigned bp);
        return bp + tag_size(bp - 4) - 8;
    endfunction

    function automatic int unsigned next_of(int unsigned bp);
        return bp + tag_size(bp - 4);
    endfunction

    function automatic int unsigned prev_of(int unsigned bp);
        return bp - tag_size(bp - 8);
    endfunction

    function automatic int unsigned coalesce(int unsigned bp);
        bit          prev_used;
        bit          next_used;
        int unsigned sz;
        prev_used = tag_used(foot_of(prev_of(bp)));
        next_used = tag_used(next_of(bp) - 4);
        sz = tag_size(bp - 4);
        if (prev_used && next_used) return bp;
        if (prev_used) begin
            sz += tag_size(next_of(bp) - 4);
            mem_wr(bp - 4, sz);
            mem_wr(foot_of(bp), sz);
        end else if (next_used) begin
            sz += tag_size(prev_of(bp) - 4);
            mem_wr(foot_of(bp), sz);
            mem_wr(prev_of(bp) - 4, sz);
            bp = prev_of(bp);
        end else begin
            sz += tag_size(prev_of(bp) - 4) + tag_size(foot_of(next_of(bp)));
            mem_wr(prev_of(bp) - 4, sz);
            mem_wr(foot_of(next_of(bp)), sz);
            bp = prev_of(bp);
        end
        // pull the rover back when it landed inside the merged block
        if (rover > bp && rover < next_of(bp)) rover = bp;
        return bp;
    endfunction

    function automatic int unsigned grow_heap(int unsigned bytes);
        int unsigned words;
        int unsigned sz;
        int unsigned bp;
        words = bytes / 4;
        sz = words[0] ? (words + 1) * 4 : words * 4;
        bp = brk;
        if (longint'(brk) + longint'(sz) > longint'(HEAP_BYTES)) return 0;
        brk += sz;
        mem_wr(bp - 4, sz);
        mem_wr(foot_of(bp), sz);
        mem_wr(next_of(bp) - 4, 1);
        return coalesce(bp);
    endfunction

    function automatic int unsigned next_fit_find(int unsigned need);
        int unsigned start;
        int unsigned n;
        start = rover;
        for (n = 0; n < WALK_MAX && tag_size(rover - 4) > 0; n++) begin
            if (!tag_used(rover - 4) && need <= tag_size(rover - 4)) return rover;
            rover = next_of(rover);
        end
        rover = FIRST_BP;
        for (n = 0; n < WALK_MAX && rover < start; n++) begin
            if (!tag_used(rover - 4) && need <= tag_size(rover - 4)) return rover;
            rover = next_of(rover);
        end
        return 0;
    endfunction

    function automatic void carve(int unsigned bp, int unsigned need);
        int unsigned have;
        have = tag_size(bp - 4);
        if (have - need >= 16 && have >= need) begin
            mem_wr(bp - 4, need | 1);
            mem_wr(foot_of(bp), need | 1);
            bp = next_of(bp);
            mem_wr(bp - 4, have - need);
            mem_wr(foot_of(bp), have - need);
        end else begin
            mem_wr(bp - 4, have | 1);
            mem_wr(foot_of(bp), have | 1);
        end
    endfunction

    function automatic void heap_init();
        foreach (heap_mem[i]) heap_mem[i] = '0;
        mem_wr(4, 9);
        mem_wr(8, 9);
        mem_wr(12, 1);
        rover = FIRST_BP;
        brk = 16;
        void'(grow_heap(CHUNK_BYTES));
    endfunction

    function automatic ilnf_pkg::rsp_t serve(ilnf_pkg::req_t r);
        ilnf_pkg::rsp_t  o;
        int unsigned     need;
        int unsigned     bp;
        int unsigned     a;
        ilnf_pkg::word_t h;
        int unsigned     sz;
        o = '0;
        if (r.func == ilnf_pkg::FUNC_ALLOC) begin
            if (r.req_size != 0) begin
                need = (r.req_size <= 8) ? 16 : 8 * ((r.req_size + 15) / 8);
                bp = next_fit_find(need);
                if (bp == 0) bp = grow_heap(need > CHUNK_BYTES ? need : CHUNK_BYTES);
                if (bp != 0) begin
                    carve(bp, need);
                    o.result_addr = bp[15:0];
                    o.ok = 1'b1;
                end
            end
        end else if (r.block_addr == 0) begin
            o.ok = 1'b1;
        end else begin
            a = r.block_addr;
            h = mem_rd(a - 4);
            sz = h & ~32'd7;
            if (a % 8 == 0 && a >= 16 && a < brk && h[0] && sz >= 16 &&
                longint'(a) + longint'(sz) <= longint'(brk)) begin
                mem_wr(a - 4, sz);
                mem_wr(foot_of(a), sz);
                void'(coalesce(a));
                o.ok = 1'b1;
            end
        end
        return o;
    endfunction

    initial begin
        fail_count = 0;
        heap_init();
    end

    always @(posedge aclk) begin
        ilnf_pkg::rsp_t want;
        if (aresetn) begin
            if (s_valid && s_ready) expected_rsp.push_back(serve(s_data));
            if (m_valid && m_ready) begin
                if (expected_rsp.size() == 0) begin
                    $error("result item with nothing expected: addr %0d ok %0d",
                           m_data.result_addr, m_data.ok);
                    fail_count++;
                end else begin
                    want = expected_rsp.pop_front();
                    if (m_data.result_addr !== want.result_addr) begin
                        $error("result_addr expected %0d actual %0d",
                               want.result_addr, m_data.result_addr);
                        fail_count++;
                    end
                    if (m_data.ok !== want.ok) begin
                        $error("ok expected %0d actual %0d", want.ok, m_data.ok);
                        fail_count++;
                    end
                end
            end
        end
    end

    function automatic int leftover();
        return expected_rsp.size();
    endfunction

endmodule

// File: tb/implicit_list_next_fit_allocator_tb.sv
`timescale 1ns / 1ps
module implicit_list_next_fit_allocator_tb;

    localparam int RANDOM_ITEMS = 700;
    localparam longint CYCLE_LIMIT = 4_000_000;

    logic           aclk = 1'b0;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    ilnf_pkg::req_t s_data;
    logic           m_valid;
    logic           m_ready;
    ilnf_pkg::rsp_t m_data;
    int             fail_count;

    int          send_idle_pct;
    int          recv_idle_pct;
    int          n_sent;
    int          n_recv;
    int          n_alloc_ok;
    int          n_alloc_fail;
    longint      cycles;
    logic [15:0] live_blocks [$];
    logic [15:0] freed_blocks [$];

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    implicit_list_next_fit_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    implicit_list_next_fit_allocator_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            n_recv++;
            if (m_data.ok && m_data.result_addr != 0) begin
                live_blocks.push_back(m_data.result_addr);
                n_alloc_ok++;
            end else if (!m_data.ok) begin
                n_alloc_fail++;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("implicit_list_next_fit_allocator_tb failed");
            $finish;
        end
    end

    task automatic send(logic func, logic [15:0] size, logic [15:0] addr);
        ilnf_pkg::req_t r;
        r.func = func;
        r.req_size = size;
        r.block_addr = addr;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (n_recv != n_sent) @(posedge aclk);
    endtask

    task automatic free_live();
        int          k;
        logic [15:0] a;
        k = $urandom_range(live_blocks.size() - 1);
        a = live_blocks[k];
        live_blocks.delete(k);
        freed_blocks.push_back(a);
        if (freed_blocks.size() > 32) void'(freed_blocks.pop_front());
        send(ilnf_pkg::FUNC_FREE, 16'($urandom), a);
    endtask

    task automatic random_item();
        int          pick;
        int          sel;
        logic [15:0] size;
        pick = $urandom_range(99);
        if (pick < 50 || (pick < 85 && live_blocks.size() == 0)) begin
            sel = $urandom_range(99);
            if (sel < 70) size = 16'($urandom_range(64, 1));
            else if (sel < 90) size = 16'($urandom_range(512, 65));
            else if (sel < 98) size = 16'($urandom_range(4096, 513));
            else size = 16'($urandom);
            send(ilnf_pkg::FUNC_ALLOC, size, 16'($urandom));
        end else if (pick < 85) begin
            free_live();
        end else if (pick < 90) begin
            send(ilnf_pkg::FUNC_FREE, 16'($urandom), 16'($urandom));
        end else if (pick < 95 && freed_blocks.size() != 0) begin
            // double free or free of a stale block
            send(ilnf_pkg::FUNC_FREE, 16'($urandom),
                 freed_blocks[$urandom_range(freed_blocks.size() - 1)]);
        end else if (live_blocks.size() != 0) begin
            send(ilnf_pkg::FUNC_FREE, 16'($urandom),
                 16'(live_blocks[$urandom_range(live_blocks.size() - 1)] +
                     $urandom_range(7, 1)));
        end else begin
            send(ilnf_pkg::FUNC_FREE, 16'($urandom), 16'($urandom_range(7, 1)));
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        m_ready <= 1'b0;
        send_idle_pct = 9;
        recv_idle_pct = 60;
        n_sent = 0;
        n_recv = 0;
        n_alloc_ok = 0;
        n_alloc_fail = 0;
        cycles = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        send(ilnf_pkg::FUNC_ALLOC, 16'd0, 16'hFFFF);
        send(ilnf_pkg::FUNC_ALLOC, 16'd1, 16'd0);
        send(ilnf_pkg::FUNC_ALLOC, 16'd8, 16'd0);
        send(ilnf_pkg::FUNC_ALLOC, 16'd9, 16'd0);
        send(ilnf_pkg::FUNC_ALLOC, 16'd24, 16'd0);
        send(ilnf_pkg::FUNC_ALLOC, 16'hFFFF, 16'd0);
        send(ilnf_pkg::FUNC_ALLOC, 16'd4000, 16'd0);
        send(ilnf_pkg::FUNC_ALLOC, 16'd5000, 16'd0);
        send(ilnf_pkg::FUNC_FREE, 16'd0, 16'd0);
        send(ilnf_pkg::FUNC_FREE, 16'd0, 16'd3);
        send(ilnf_pkg::FUNC_FREE, 16'd0, 16'd8);
        send(ilnf_pkg::FUNC_FREE, 16'hFFFF, 16'hFFF8);
        send(ilnf_pkg::FUNC_FREE, 16'd0, 16'd4112);
        drain();
        free_live();
        free_live();
        send(ilnf_pkg::FUNC_FREE, 16'd0, freed_blocks[0]);
        free_live();
        free_live();
        send(ilnf_pkg::FUNC_ALLOC, 16'd60000, 16'd0);
        send(ilnf_pkg::FUNC_ALLOC, 16'd40000, 16'd0);
        send(ilnf_pkg::FUNC_ALLOC, 16'd40000, 16'd0);
        send(ilnf_pkg::FUNC_ALLOC, 16'd16, 16'd0);
        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3) begin
                drain();
                send_idle_pct = 60;
                recv_idle_pct = 9;
            end else if (i == 2 * RANDOM_ITEMS / 3) begin
                drain();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_item();
        end

        drain();
        repeat (200) @(posedge aclk);
        $display("Sent %0d items: %0d allocations succeeded, %0d requests refused,",
                 n_sent, n_alloc_ok, n_alloc_fail);
        $display("covering splits, growth, heap exhaustion, coalescing and bad frees.");
        if (fail_count == 0 && chk.leftover() == 0) begin
            $display("implicit_list_next_fit_allocator_tb passed");
        end else begin
            $display("implicit_list_next_fit_allocator_tb failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/ilnf_pkg.sv
design/ilnf_ram.sv
design/implicit_list_next_fit_allocator.sv
tb/implicit_list_next_fit_allocator_checker.sv
tb/implicit_list_next_fit_allocator_tb.sv
